/* hdl/a85_pkg.sv */
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types and constants for the ascii85 stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

    // item operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_INCOMPL  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_Z_IN_GRP = 3'd4;

    // characters of interest
    localparam logic [7:0] CH_EXCL  = 8'h21;  // '!', digit zero
    localparam logic [7:0] CH_U     = 8'h75;  // 'u', digit 84
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [6:0] RADIX = 7'd85;

    // register map
    localparam logic REG_FRAMING = 1'b0;

    // framing phase
    typedef enum logic [2:0] {
        PH_SEEK,
        PH_LT,
        PH_IN,
        PH_TILDE,
        PH_DONE
    } t_phase;

    // decoder state carried between items
    typedef struct packed {
        t_phase      phase;
        logic [31:0] group_value;
        logic [2:0]  digit_count;
        logic        error_latched;
    } t_state;

    // block of results caused by one item
    typedef struct packed {
        logic        emit;
        logic [31:0] word;
        logic [2:0]  count;
        logic        has_byte;
        logic [2:0]  status;
        logic        message_end;
    } t_result;

endpackage

/* hdl/a85_in_if.sv */
// ----------------------------------------------------------------------------
// a85_in_if
// Character channel: valid/ready handshake with op and character payload.
// ----------------------------------------------------------------------------
interface a85_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

/* hdl/a85_out_if.sv */
// ----------------------------------------------------------------------------
// a85_out_if
// Result channel: valid/ready handshake with one decoded byte or status-only result per transfer.
// ----------------------------------------------------------------------------
interface a85_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic [2:0] status;
    logic       message_end;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output status,
                    output message_end, output last, input ready);
    modport sink   (input valid, input data_byte, input has_byte, input status,
                    input message_end, input last, output ready);
endinterface

/* hdl/a85_step.sv */
// ----------------------------------------------------------------------------
// a85_step
// Next-state and result logic for one input item: framing, digit
// accumulation, group completion and end-of-input flush.
// ----------------------------------------------------------------------------
module a85_step
    import a85_pkg::*;
(
    input  t_state     i_state,
    input  logic       i_framing,
    input  logic       i_op,
    input  logic [7:0] i_char,
    output t_state     o_state,
    output t_result    o_result
);

    logic        decode;
    logic        flush;
    logic [2:0]  end_status;
    logic [6:0]  digit;
    logic [38:0] acc;
    logic [19:0] pad_mul;
    logic [51:0] padded;

    // digit accumulate: value * 85 + digit
    assign digit = 7'(i_char - CH_EXCL);
    assign acc   = {7'd0, i_state.group_value} * {32'd0, RADIX} + {32'd0, digit};

    // pad with 'u' digits: value * 85^k + (85^k - 1)
    always_comb begin
        case (i_state.digit_count)
            3'd2:    pad_mul = 20'd614125;
            3'd3:    pad_mul = 20'd7225;
            default: pad_mul = 20'd85;
        endcase
    end
    assign padded = {20'd0, i_state.group_value} * {32'd0, pad_mul}
                  + {32'd0, pad_mul} - 52'd1;

    // item decision
    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        decode     = 1'b0;
        flush      = 1'b1;
        end_status = ST_OK;

        if (i_op == OP_END) begin
            // end of input: flush and return to the start state
            if (i_framing) begin
                case (i_state.phase)
                    PH_SEEK, PH_LT: flush = 1'b0;
                    PH_TILDE: begin
                        flush      = 1'b0;
                        end_status = ST_INVALID;
                    end
                    default: flush = 1'b1;
                endcase
            end
            o_result.emit        = 1'b1;
            o_result.count       = 3'd1;
            o_result.message_end = 1'b1;
            if (i_state.error_latched) begin
                o_result.status = ST_OK;
            end else if (flush && i_state.digit_count == 3'd1) begin
                o_result.status = ST_INCOMPL;
            end else if (flush && i_state.digit_count != 3'd0) begin
                if (padded[51:32] != 20'd0) begin
                    o_result.status = ST_OVERFLOW;
                end else begin
                    o_result.word     = padded[31:0];
                    o_result.count    = i_state.digit_count - 3'd1;
                    o_result.has_byte = 1'b1;
                end
            end else begin
                o_result.status = end_status;
            end
            o_state.phase         = PH_SEEK;
            o_state.group_value   = '0;
            o_state.digit_count   = '0;
            o_state.error_latched = 1'b0;
        end else if (!i_state.error_latched) begin
            if (!i_framing) begin
                decode = 1'b1;
            end else begin
                // marker tracking
                case (i_state.phase)
                    PH_SEEK: begin
                        if (i_char == CH_LT) o_state.phase = PH_LT;
                    end
                    PH_LT: begin
                        if (i_char == CH_TILDE)   o_state.phase = PH_IN;
                        else if (i_char != CH_LT) o_state.phase = PH_SEEK;
                    end
                    PH_IN: begin
                        if (i_char == CH_TILDE) o_state.phase = PH_TILDE;
                        else                    decode = 1'b1;
                    end
                    PH_TILDE: begin
                        if (i_char == CH_GT) begin
                            o_state.phase = PH_DONE;
                        end else begin
                            o_state.phase         = PH_IN;
                            o_state.error_latched = 1'b1;
                            o_result.emit         = 1'b1;
                            o_result.count        = 3'd1;
                            o_result.status       = ST_INVALID;
                        end
                    end
                    default: o_state.phase = i_state.phase;
                endcase
            end

            // character decode
            if (decode) begin
                if (i_char inside {8'h20, [8'h09:8'h0D]}) begin
                    o_state.phase = o_state.phase;
                end else if (i_char == CH_Z) begin
                    o_result.emit  = 1'b1;
                    o_result.count = (i_state.digit_count != 3'd0) ? 3'd1 : 3'd4;
                    if (i_state.digit_count != 3'd0) begin
                        o_state.error_latched = 1'b1;
                        o_result.status       = ST_Z_IN_GRP;
                    end else begin
                        o_result.has_byte = 1'b1;
                    end
                end else if (i_char < CH_EXCL || i_char > CH_U) begin
                    o_state.error_latched = 1'b1;
                    o_result.emit         = 1'b1;
                    o_result.count        = 3'd1;
                    o_result.status       = ST_INVALID;
                end else if (i_state.digit_count < 3'd4) begin
                    o_state.group_value = acc[31:0];
                    o_state.digit_count = i_state.digit_count + 3'd1;
                end else if (acc[38:32] != 7'd0) begin
                    o_state.error_latched = 1'b1;
                    o_result.emit         = 1'b1;
                    o_result.count        = 3'd1;
                    o_result.status       = ST_OVERFLOW;
                end else begin
                    o_state.group_value = '0;
                    o_state.digit_count = '0;
                    o_result.emit       = 1'b1;
                    o_result.count      = 3'd4;
                    o_result.has_byte   = 1'b1;
                    o_result.word       = acc[31:0];
                end
            end
        end
    end

endmodule

/* hdl/ascii85_stream_decoder.sv */
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Ascii85 character stream to byte stream decoder with optional <~ ~> framing.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one character (op 0) or end of input (op 1) per transfer.
//   o_out : one result per transfer; a decoded byte, or a status-only result
//           on error or at end of input. last marks the final result caused
//           by one input item, message_end the final result of an end item.
//   APB   : register 0 at address 0, bit 0 = framing enable (reset 1).
// Latency: results of an item appear on o_out the cycle after its transfer.
// Throughput: one character per cycle. An item that causes results waits
//   until the result buffer has drained down to its final result, so after a
//   completed group or a z the next result-producing item waits for the
//   earlier results to drain; items that cause no result are taken every cycle.
// Stall: when o_out is held, up to four results wait in the buffer and
//   i_in keeps taking items that cause no results.
// Reset: decoder state is cleared, framing is enabled and the buffer is
//   emptied; no result is pending after reset.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder
    import a85_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    a85_in_if.sink      i_in,
    a85_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state      r_state;
    t_state      n_state;
    t_result     step;
    logic        r_framing;
    logic [31:0] r_word;
    logic [2:0]  r_rem;
    logic        r_has;
    logic [2:0]  r_status;
    logic        r_mend;
    logic        in_xfer;
    logic        out_xfer;
    logic        buf_free;

    // per-item decode logic
    a85_step u_step (
        .i_state   (r_state),
        .i_framing (r_framing),
        .i_op      (i_in.op),
        .i_char    (i_in.char_code),
        .o_state   (n_state),
        .o_result  (step)
    );

    // handshakes
    assign out_xfer   = o_out.valid && o_out.ready;
    assign buf_free   = (r_rem == 3'd0) || (r_rem == 3'd1 && o_out.ready);
    assign i_in.ready = buf_free || (i_in.valid && !step.emit);
    assign in_xfer    = i_in.valid && i_in.ready;

    // result buffer outputs, most significant byte first
    assign o_out.valid       = (r_rem != 3'd0);
    assign o_out.data_byte   = r_word[31:24];
    assign o_out.has_byte    = r_has;
    assign o_out.status      = r_status;
    assign o_out.last        = (r_rem == 3'd1);
    assign o_out.message_end = r_mend && (r_rem == 3'd1);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAMING) ? {31'd0, r_framing} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framing <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_FRAMING) begin
            r_framing <= pwdata[0];
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_SEEK;
            r_state.group_value   <= '0;
            r_state.digit_count   <= '0;
            r_state.error_latched <= 1'b0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // result buffer: load on a transfer that emits, shift out per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (in_xfer && step.emit) begin
            r_rem <= step.count;
        end else if (out_xfer) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && step.emit) begin
            r_word   <= step.word;
            r_has    <= step.has_byte;
            r_status <= step.status;
            r_mend   <= step.message_end;
        end else if (out_xfer) begin
            r_word <= {r_word[23:0], 8'd0};
        end
    end

endmodule
